>>> rtl/core/tti_pkg.sv
// tti_pkg: shared widths, constants and the datasheet table of the thermistor interpolator
// used by tti_div, thermistor_table_interpolator_core and tb
`default_nettype none

package tti_pkg;

    localparam int TABLE_ENTRIES_DEF = 166;
    localparam int DS_ROWS           = 166;
    localparam int ROM_IDX_W         = 8;
    localparam int RES_IN_W          = 22;
    localparam int ROM_R_W           = 21;
    localparam int ROM_T_W           = 8;
    localparam int ROM_WORD_W        = ROM_R_W + ROM_T_W;
    localparam int TEMP_W            = 18;
    localparam int DIV_W             = 40;
    localparam int DEN_W             = 21;
    localparam int SUM_W             = 42;
    localparam int TEMP_OFFSET       = 40;

    // datasheet resistance in 0.1 ohm, -40 C to 125 C in 1 C steps
    localparam int unsigned DS_R [DS_ROWS] = '{
        1956520, 1849171, 1748452, 1653910, 1565125, 1481710, 1403304, 1329576,
        1260215, 1194936, 1133471, 1075649, 1021155, 969776, 921315, 875588,
        832424, 791663, 753157, 716768, 682367, 649907, 619190, 590113,
        562579, 536496, 511779, 488349, 466132, 445058, 425062, 405997,
        387905, 370729, 354417, 338922, 324197, 310200, 296890, 284231,
        272186, 260760, 249877, 239509, 229629, 220211, 211230, 202666,
        194495, 186698, 179255, 172139, 165344, 158856, 152658, 146735,
        141075, 135664, 130489, 125540, 120805, 116281, 111947, 107795,
        103815, 100000, 96342, 92835, 89470, 86242, 83145, 80181,
        77337, 74609, 71991, 69479, 67067, 64751, 62526, 60390,
        58336, 56357, 54454, 52623, 50863, 49169, 47539, 45971,
        44461, 43008, 41609, 40262, 38964, 37714, 36510, 35350,
        34231, 33152, 32113, 31110, 30143, 29224, 28337, 27482,
        26657, 25861, 25093, 24351, 23635, 22943, 22275, 21627,
        21001, 20396, 19811, 19245, 18698, 18170, 17658, 17164,
        16685, 16224, 15777, 15345, 14927, 14521, 14129, 13749,
        13381, 13025, 12680, 12343, 12016, 11700, 11393, 11096,
        10807, 10528, 10256, 9993, 9738, 9492, 9254, 9022,
        8798, 8580, 8368, 8162, 7963, 7769, 7580, 7397,
        7219, 7046, 6878, 6715, 6556, 6402, 6252, 6106,
        5964, 5826, 5692, 5562, 5435, 5311
    };

    // table word {resistance, temperature}; rows past the datasheet read as zero
    function automatic logic [ROM_WORD_W-1:0] rom_word(input logic [ROM_IDX_W-1:0] idx);
        logic [ROM_R_W-1:0] r;
        logic [ROM_T_W-1:0] t;
        r = '0;
        t = '0;
        if (int'(idx) < DS_ROWS)
        begin
            r = ROM_R_W'(DS_R[idx]);
            t = idx - ROM_T_W'(TEMP_OFFSET);
        end
        return {r, t};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/thermistor_table_interpolator_core.sv
// thermistor_table_interpolator_core: nearest-entry search and linear interpolation
// over a resistance/temperature table; depends on tti_pkg, tti_ram and tti_div
`default_nettype none

// usage
//   request channel (req_valid/req_ready) carries one word: a resistance in 0.1 ohm
//   response channel (rsp_valid/rsp_ready) returns one word per request:
//   temperature in Q9.8 degrees C, index of the nearest table entry, and a clip flag
//   after reset the table ram is loaded from the package, one entry per cycle;
//   req_ready stays low until the load is done
//   one request is worked at a time, through the single read port of the table ram:
//   the linear scan, then fetching the two neighbor entries and the slope product,
//   setting up the divide, the bit-serial divide and the final add and saturate;
//   when the nearest entry is the last one, or its successor has the same
//   resistance, the divide is skipped
//   results wait in an output register: a new request is taken while a result
//   is still held; a finished item stalls only if the previous result is
//   not yet taken

module thermistor_table_interpolator_core
    import tti_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    output logic                          req_ready,
    input  wire logic [RES_IN_W-1:0]      resistance,
    output logic                          rsp_valid,
    input  wire logic                     rsp_ready,
    output logic signed [TEMP_W-1:0]      temperature,
    output logic        [ROM_IDX_W-1:0]   nearest_index,
    output logic                          clipped
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

    localparam logic [3:0] S_FILL   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_FETCH0 = 4'd3;
    localparam logic [3:0] S_FETCH1 = 4'd4;
    localparam logic [3:0] S_FETCH2 = 4'd5;
    localparam logic [3:0] S_DIVGO  = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(131071);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(131072);

    logic [3:0]              state_reg;
    logic [3:0]              state_next;

    // table ram
    logic                    ram_we;
    logic [AW-1:0]           ram_raddr;
    logic [ROM_WORD_W-1:0]   ram_wdata;
    logic [ROM_WORD_W-1:0]   ram_rdata;
    logic [ROM_R_W-1:0]      rd_r;
    logic [ROM_T_W-1:0]      rd_t;

    logic [AW-1:0]           fill_reg;
    logic [AW-1:0]           scan_addr_reg;
    logic                    issue_reg;
    logic                    rd_valid_reg;
    logic [AW-1:0]           rd_idx_reg;

    logic [RES_IN_W-1:0]     x_reg;
    logic [AW-1:0]           best_reg;
    logic [RES_IN_W-1:0]     best_diff_reg;
    logic [ROM_R_W-1:0]      x0_reg;
    logic [ROM_T_W-1:0]      y0_reg;

    logic signed [31:0]      prod_reg;
    logic signed [ROM_R_W:0] den_reg;
    logic                    neg_reg;
    logic [DIV_W-1:0]        quo_reg;

    // scan compare
    logic signed [RES_IN_W:0] diff_s;
    logic [RES_IN_W-1:0]      diff_abs;

    // slope terms
    logic signed [RES_IN_W:0] dx;
    logic signed [ROM_T_W:0]  dy;
    logic signed [ROM_R_W:0]  den;
    logic [31:0]              prod_abs;
    logic [DEN_W-1:0]         den_abs;

    // divider
    logic                    div_start;
    logic                    div_done;
    logic [DIV_W-1:0]        div_quotient;

    // final sum
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] q_s;
    logic signed [SUM_W-1:0] sum;
    logic signed [TEMP_W-1:0] temp_sat;
    logic                    clip_sat;
    logic                    load_out;

    logic signed [TEMP_W-1:0] temperature_reg;
    logic [ROM_IDX_W-1:0]     nearest_index_reg;
    logic                     clipped_reg;
    logic                     rsp_valid_reg;

    assign rd_r = ram_rdata[ROM_WORD_W-1:ROM_T_W];
    assign rd_t = ram_rdata[ROM_T_W-1:0];

    assign ram_we    = (state_reg == S_FILL);
    assign ram_wdata = rom_word(ROM_IDX_W'(fill_reg));

    tti_ram #(
        .WIDTH (ROM_WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // read address by phase: scan pointer, then best entry, then its successor
    always_comb
    begin
        case (state_reg)
            S_FETCH0: ram_raddr = best_reg;
            S_FETCH1: ram_raddr = best_reg + 1'b1;
            default:  ram_raddr = scan_addr_reg;
        endcase
    end

    assign diff_s   = $signed({1'b0, x_reg}) - $signed({2'b0, rd_r});
    assign diff_abs = diff_s[RES_IN_W] ? RES_IN_W'(-diff_s) : diff_s[RES_IN_W-1:0];

    assign dx  = $signed({1'b0, x_reg}) - $signed({2'b0, x0_reg});
    assign dy  = $signed({rd_t[ROM_T_W-1], rd_t}) - $signed({y0_reg[ROM_T_W-1], y0_reg});
    assign den = $signed({1'b0, rd_r}) - $signed({1'b0, x0_reg});

    assign prod_abs = prod_reg[31] ? 32'(-prod_reg) : prod_reg;
    // both table resistances fit 21 bits, so the magnitude of their difference does too
    assign den_abs  = den_reg[ROM_R_W] ? DEN_W'(-den_reg) : DEN_W'(den_reg);

    assign div_start = (state_reg == S_DIVGO) && (den_reg != '0);

    tti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({prod_abs, 8'b0}),
        .divisor  (den_abs),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // y0 * 256 plus the signed quotient, then saturate to the output range
    assign base = SUM_W'($signed(y0_reg)) <<< 8;
    assign q_s  = neg_reg ? -$signed({2'b0, quo_reg}) : $signed({2'b0, quo_reg});
    assign sum  = base + q_s;

    always_comb
    begin
        temp_sat = sum[TEMP_W-1:0];
        clip_sat = 1'b0;
        if (sum > SAT_MAX)
        begin
            temp_sat = SAT_MAX[TEMP_W-1:0];
            clip_sat = 1'b1;
        end
        else if (sum < SAT_MIN)
        begin
            temp_sat = SAT_MIN[TEMP_W-1:0];
            clip_sat = 1'b1;
        end
    end

    assign load_out = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_FILL:
            begin
                if (fill_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_valid_reg && rd_idx_reg == LAST)
                begin
                    state_next = S_FETCH0;
                end
            end
            S_FETCH0: state_next = S_FETCH1;
            S_FETCH1: state_next = (best_reg == LAST) ? S_DONE : S_FETCH2;
            S_FETCH2: state_next = S_DIVGO;
            S_DIVGO:  state_next = (den_reg == '0) ? S_DONE : S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            fill_reg      <= '0;
            issue_reg     <= 1'b0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == S_SCAN) && issue_reg;
            if (state_reg == S_FILL && fill_reg != LAST)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (state_reg == S_IDLE && req_valid)
            begin
                issue_reg <= 1'b1;
            end
            else if (state_reg == S_SCAN && issue_reg && scan_addr_reg == LAST)
            begin
                issue_reg <= 1'b0;
            end
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                x_reg         <= resistance;
                scan_addr_reg <= '0;
            end
            S_SCAN:
            begin
                if (issue_reg && scan_addr_reg != LAST)
                begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
                // strict less-than keeps the lowest index on a tie
                if (rd_valid_reg && (rd_idx_reg == '0 || diff_abs < best_diff_reg))
                begin
                    best_reg      <= rd_idx_reg;
                    best_diff_reg <= diff_abs;
                end
            end
            S_FETCH1:
            begin
                x0_reg  <= rd_r;
                y0_reg  <= rd_t;
                quo_reg <= '0;
                neg_reg <= 1'b0;
            end
            S_FETCH2:
            begin
                prod_reg <= dx * dy;
                den_reg  <= den;
            end
            S_DIVGO:
            begin
                neg_reg <= prod_reg[31] ^ den_reg[ROM_R_W];
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    quo_reg <= div_quotient;
                end
            end
            default:
            begin
            end
        endcase
        rd_idx_reg <= scan_addr_reg;
        if (load_out)
        begin
            temperature_reg   <= temp_sat;
            nearest_index_reg <= ROM_IDX_W'(best_reg);
            clipped_reg       <= clip_sat;
        end
    end

    assign req_ready     = (state_reg == S_IDLE);
    assign rsp_valid     = rsp_valid_reg;
    assign temperature   = temperature_reg;
    assign nearest_index = nearest_index_reg;
    assign clipped       = clipped_reg;

endmodule

`default_nettype wire

>>> rtl/core/tti_ram.sv
// tti_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/tti_div.sv
// tti_div: unsigned restoring divider, one quotient bit per cycle
// depends on tti_pkg
`default_nettype none

module tti_div
    import tti_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic      [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> sim/tb.sv
// tb: self-checking bench for thermistor_table_interpolator_core
// holds its own nearest-entry and interpolation predictor; depends on tti_pkg and the core rtl
`timescale 1ns / 100ps

module tb;
    import tti_pkg::*;

    localparam int  TBL_N     = TABLE_ENTRIES_DEF;
    localparam int  TBL_USED  = (TBL_N < 2) ? 2 : ((TBL_N > 256) ? 256 : TBL_N);
    localparam int  TBL_CAP   = 256;
    localparam int  N_RANDOM  = 1300;
    localparam int  DRAIN_GAP = 250;
    localparam int  TAIL_WAIT = 300;
    localparam int  LIMIT     = 3000000;
    localparam longint T_MAX  = 131071;
    localparam longint T_MIN  = -131072;

    // one request word and whether the sender drains first
    typedef struct packed
    {
        logic [RES_IN_W-1:0] ohms;
        logic                drain;
    } sample_t;

    // one response word as the core should return it
    typedef struct packed
    {
        logic signed [TEMP_W-1:0] temp;
        logic [ROM_IDX_W-1:0]     idx;
        logic                     clip;
    } reading_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_BLOCK} rx_mode_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     req_valid = 1'b0;
    logic                     req_ready;
    logic [RES_IN_W-1:0]      resistance = '0;
    logic                     rsp_valid;
    logic                     rsp_ready = 1'b0;
    logic signed [TEMP_W-1:0] temperature;
    logic [ROM_IDX_W-1:0]     nearest_index;
    logic                     clipped;

    // local copy of the lookup table
    longint    tbl_ohms [TBL_CAP];
    longint    tbl_degc [TBL_CAP];

    sample_t   samples_todo [$];
    reading_t  readings_due [$];
    int        errors = 0;
    int        cycle_count = 0;

    // sender burst state
    int        burst_left = 4;
    int        gap_left = 0;
    logic      next_valid;
    logic [RES_IN_W-1:0] next_ohms;
    sample_t   head;

    // receiver stall state
    rx_mode_t  rx_mode = RX_OPEN;
    int        rx_mode_left = 0;
    int        rx_stall_left = 0;
    logic      next_ready;
    reading_t  got;
    reading_t  want;

    thermistor_table_interpolator_core #(
        .TABLE_ENTRIES (TBL_N)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .resistance    (resistance),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .temperature   (temperature),
        .nearest_index (nearest_index),
        .clipped       (clipped)
    );

    always #10 clk = ~clk;

    // nearest entry by absolute difference, lowest index on a tie, then a
    // linear step toward the next entry, if any, with truncating division
    function automatic reading_t interpolate_temp(input logic [RES_IN_W-1:0] x_in);
        longint   x;
        longint   d;
        longint   best_d;
        longint   den;
        longint   q;
        longint   t;
        int       best;
        reading_t rd;
        x = longint'(x_in);
        best = 0;
        best_d = x - tbl_ohms[0];
        if (best_d < 0)
            best_d = -best_d;
        for (int i = 1; i < TBL_USED; i++)
        begin
            d = x - tbl_ohms[i];
            if (d < 0)
                d = -d;
            if (d < best_d)
            begin
                best_d = d;
                best = i;
            end
        end
        if (best < TBL_USED - 1)
        begin
            den = tbl_ohms[best + 1] - tbl_ohms[best];
            q = 0;
            // flat segment: no slope, stay on the entry
            if (den != 0)
                q = ((x - tbl_ohms[best]) * (tbl_degc[best + 1] - tbl_degc[best]) * 256) / den;
            t = tbl_degc[best] * 256 + q;
        end
        else
        begin
            t = tbl_degc[TBL_USED - 1] * 256;
        end
        rd.clip = 1'b0;
        if (t > T_MAX)
        begin
            t = T_MAX;
            rd.clip = 1'b1;
        end
        if (t < T_MIN)
        begin
            t = T_MIN;
            rd.clip = 1'b1;
        end
        rd.temp = TEMP_W'(t);
        rd.idx  = ROM_IDX_W'(best);
        return rd;
    endfunction

    function automatic sample_t mk_sample(input longint v, input logic drain);
        sample_t s;
        if (v < 0)
            v = 0;
        if (v > 64'h3FFFFF)
            v = 64'h3FFFFF;
        s.ohms  = RES_IN_W'(v);
        s.drain = drain;
        return s;
    endfunction

    // random resistance, mostly near or between table entries
    function automatic longint pick_ohms();
        int     sel;
        int     i;
        longint span;
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            i = $urandom_range(0, TBL_USED - 1);
            return tbl_ohms[i] + longint'($urandom_range(0, 2000)) - 1000;
        end
        else if (sel < 6)
        begin
            i = $urandom_range(0, TBL_USED - 2);
            span = tbl_ohms[i] - tbl_ohms[i + 1];
            if (span < 0)
                span = -span;
            return tbl_ohms[i + 1] + longint'($urandom % (span + 1));
        end
        else if (sel < 8)
            return longint'($urandom_range(5311, 1956520));
        else if (sel < 9)
            return longint'($urandom & 32'h3FFFFF);
        else
            return longint'($urandom_range(0, 6000));
    endfunction

    // stimulus, then drain and final verdict
    initial
    begin
        int     tie_rows [4];
        longint s;
        tie_rows = '{0, 64, 120, 164};
        for (int i = 0; i < TBL_CAP; i++)
        begin
            if (i < DS_ROWS)
            begin
                tbl_ohms[i] = longint'(DS_R[i]) & 64'h1FFFFF;
                tbl_degc[i] = longint'(i) - 40;
            end
            else
            begin
                tbl_ohms[i] = 0;
                tbl_degc[i] = 0;
            end
        end

        // directed: field extremes, table ends, exact hits and midpoint ties
        samples_todo.push_back(mk_sample(0, 1'b0));
        samples_todo.push_back(mk_sample(64'h3FFFFF, 1'b0));
        samples_todo.push_back(mk_sample(64'h1FFFFF, 1'b0));
        samples_todo.push_back(mk_sample(64'h200000, 1'b0));
        samples_todo.push_back(mk_sample(tbl_ohms[0], 1'b0));
        samples_todo.push_back(mk_sample(tbl_ohms[0] + 1, 1'b0));
        samples_todo.push_back(mk_sample(tbl_ohms[TBL_USED - 1], 1'b0));
        samples_todo.push_back(mk_sample(tbl_ohms[TBL_USED - 1] - 1, 1'b0));
        samples_todo.push_back(mk_sample(tbl_ohms[TBL_USED - 1] + 1, 1'b0));
        samples_todo.push_back(mk_sample(1, 1'b1));
        samples_todo.push_back(mk_sample(tbl_ohms[65], 1'b0));
        samples_todo.push_back(mk_sample(tbl_ohms[100], 1'b0));
        samples_todo.push_back(mk_sample(tbl_ohms[100] + 1, 1'b0));
        samples_todo.push_back(mk_sample(3000000, 1'b0));
        foreach (tie_rows[k])
        begin
            s = tbl_ohms[tie_rows[k]] + tbl_ohms[tie_rows[k] + 1];
            samples_todo.push_back(mk_sample(s / 2, 1'b0));
            samples_todo.push_back(mk_sample(s / 2 + 1, 1'b0));
        end

        for (int n = 0; n < N_RANDOM; n++)
            samples_todo.push_back(mk_sample(pick_ohms(), (n % DRAIN_GAP) == 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (samples_todo.size() != 0 || req_valid)
            @(posedge clk);
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // request driver: bursts of words with random gaps, draining when told to
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            next_valid = req_valid;
            next_ohms  = resistance;
            if (req_valid && req_ready)
                readings_due.push_back(interpolate_temp(resistance));
            if (!req_valid || req_ready)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (samples_todo.size() != 0)
                begin
                    head = samples_todo[0];
                    // hold off until every outstanding word has come back
                    if (!(head.drain && readings_due.size() != 0))
                    begin
                        void'(samples_todo.pop_front());
                        next_valid = 1'b1;
                        next_ohms  = head.ohms;
                        burst_left--;
                        if (burst_left <= 0)
                        begin
                            burst_left = $urandom_range(1, 12);
                            if ($urandom_range(0, 3) == 0)
                                gap_left = 0;
                            else if ($urandom_range(0, 4) == 0)
                                gap_left = $urandom_range(20, 60);
                            else
                                gap_left = $urandom_range(1, 20);
                        end
                    end
                end
            end
            req_valid  <= next_valid;
            resistance <= next_ohms;
        end
    end

    // response monitor with its own stall pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                got.temp = temperature;
                got.idx  = nearest_index;
                got.clip = clipped;
                if (readings_due.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected word: temperature %0d index %0d clipped %0d",
                             $time, got.temp, got.idx, got.clip);
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (got.temp !== want.temp)
                    begin
                        errors++;
                        $display("%0t temperature mismatch: expected %0d actual %0d",
                                 $time, want.temp, got.temp);
                    end
                    if (got.idx !== want.idx)
                    begin
                        errors++;
                        $display("%0t nearest_index mismatch: expected %0d actual %0d",
                                 $time, want.idx, got.idx);
                    end
                    if (got.clip !== want.clip)
                    begin
                        errors++;
                        $display("%0t clipped mismatch: expected %0d actual %0d",
                                 $time, want.clip, got.clip);
                    end
                end
            end

            if (rx_mode_left <= 0)
            begin
                case ($urandom_range(0, 5))
                    0, 1, 2: rx_mode = RX_OPEN;
                    3, 4:    rx_mode = RX_COIN;
                    default: rx_mode = RX_BLOCK;
                endcase
                rx_mode_left = $urandom_range(50, 600);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_OPEN: next_ready = 1'b1;
                RX_COIN: next_ready = 1'($urandom_range(0, 1));
                default:
                begin
                    if (rx_stall_left > 0)
                    begin
                        rx_stall_left--;
                        next_ready = 1'b0;
                    end
                    else
                    begin
                        next_ready = 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            rx_stall_left = $urandom_range(1, 250);
                    end
                end
            endcase
            rsp_ready <= next_ready;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

>>> filelist.f
rtl/core/tti_pkg.sv
rtl/core/tti_ram.sv
rtl/core/tti_div.sv
rtl/core/thermistor_table_interpolator_core.sv
sim/tb.sv
